>>> design/fdld_pkg.sv
// ----------------------------------------------------------------------------
// fdld_pkg
// Shared widths, types and register codes of the line derivative unit.
// ----------------------------------------------------------------------------
package fdld_pkg;

  localparam int unsigned MaxLine = 4096;
  localparam int unsigned MinLine = 4;
  localparam int unsigned PosW    = $clog2(MaxLine);
  localparam int unsigned LenEffW = PosW + 1;
  localparam int unsigned LenW    = 13;
  localparam int unsigned IdxW    = 12;
  localparam int unsigned DataW   = 32;
  localparam int unsigned SumW    = 36;
  localparam int unsigned MagHiW  = SumW - DataW;
  localparam int unsigned ProdW   = SumW + DataW;
  localparam int unsigned CfgIdxW = 2;

  localparam int unsigned SlopeShift = 17;
  localparam int unsigned CurvShift  = 16;

  typedef enum logic [CfgIdxW-1:0] {
    CfgLineLength = 2'd0,
    CfgInvStep    = 2'd1,
    CfgInvStepSq  = 2'd2
  } cfg_reg_e;

  typedef logic signed [DataW-1:0] sample_t;
  typedef logic signed [SumW-1:0]  sum_t;

endpackage

>>> design/fdld_cell.sv
// ----------------------------------------------------------------------------
// fdld_cell
// One tap of the sample window; takes its neighbor's sample on each beat.
// ----------------------------------------------------------------------------
module fdld_cell (
  input  logic              clk_i,
  input  logic              en_i,
  input  fdld_pkg::sample_t d_i,
  output fdld_pkg::sample_t q_o
);

  fdld_pkg::sample_t tap_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tap_q <= d_i;
    end
  end

  assign q_o = tap_q;

endmodule

>>> design/fdld_scale.sv
// ----------------------------------------------------------------------------
// fdld_scale
// Three-stage scaling lane: magnitude, split product, round and saturate.
// ----------------------------------------------------------------------------
module fdld_scale (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic                       half_i,
  input  fdld_pkg::sum_t             num_i,
  input  logic [fdld_pkg::DataW-1:0] k_i,
  output fdld_pkg::sample_t          res_o,
  output logic                       sat_o
);

  localparam int unsigned DataW = fdld_pkg::DataW;
  localparam int unsigned SumW  = fdld_pkg::SumW;
  localparam int unsigned ProdW = fdld_pkg::ProdW;
  localparam int unsigned HiW   = fdld_pkg::MagHiW + DataW;

  logic              neg1_q;
  logic [SumW-1:0]   mag_q;
  logic [SumW-1:0]   mag_d;
  logic              neg2_q;
  logic [2*DataW-1:0] plo_q;
  logic [HiW-1:0]    phi_q;
  logic [ProdW-1:0]  rnd;
  logic [ProdW-1:0]  total;
  logic [ProdW-1:0]  qfull;
  logic [ProdW-1:0]  lim_neg;
  logic [ProdW-1:0]  lim_pos;
  fdld_pkg::sample_t res_d;
  fdld_pkg::sample_t res_q;
  logic              sat_d;
  logic              sat_q;

  always_comb begin
    if (num_i[SumW-1]) begin
      mag_d = SumW'(~num_i) + SumW'(1);
    end else begin
      mag_d = SumW'(num_i);
    end
  end

  always_comb begin
    lim_neg = ProdW'(1) << (DataW - 1);
    lim_pos = lim_neg - ProdW'(1);
    if (half_i) begin
      rnd = ProdW'(1) << (fdld_pkg::SlopeShift - 1);
    end else begin
      rnd = ProdW'(1) << (fdld_pkg::CurvShift - 1);
    end
    total = {phi_q, {DataW{1'b0}}} + ProdW'(plo_q) + rnd;
    if (half_i) begin
      qfull = total >> fdld_pkg::SlopeShift;
    end else begin
      qfull = total >> fdld_pkg::CurvShift;
    end
    sat_d = 1'b0;
    if (neg2_q) begin
      if (qfull > lim_neg) begin
        sat_d = 1'b1;
        res_d = fdld_pkg::sample_t'(lim_neg[DataW-1:0]);
      end else begin
        res_d = fdld_pkg::sample_t'(~qfull[DataW-1:0] + DataW'(1));
      end
    end else begin
      if (qfull > lim_pos) begin
        sat_d = 1'b1;
        res_d = fdld_pkg::sample_t'(lim_pos[DataW-1:0]);
      end else begin
        res_d = fdld_pkg::sample_t'(qfull[DataW-1:0]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg1_q <= num_i[SumW-1];
      mag_q  <= mag_d;
      neg2_q <= neg1_q;
      plo_q  <= mag_q[DataW-1:0] * k_i;
      phi_q  <= mag_q[SumW-1:DataW] * k_i;
      res_q  <= res_d;
      sat_q  <= sat_d;
    end
  end

  assign res_o = res_q;
  assign sat_o = sat_q;

endmodule

>>> design/finite_difference_line_derivatives_unit.sv
// ----------------------------------------------------------------------------
// finite_difference_line_derivatives_unit
// Streams grid line samples and gives first and second derivatives per point.
// ----------------------------------------------------------------------------
// usage:
//   input beat: one signed Q16.16 sample per point, in point order. samples
//   0..2 of a line give no result, sample 3 gives points 0..2 (and 3 for a
//   four-point line), every later sample gives the previous point, and the
//   last sample also gives the last point with end_of_line set.
//   output beat: slope, curvature, point_index, end_of_line, last_of_run
//   (last result of the input beat) and saturated.
//   config: cfg_index_i 0 line_length, 1 inv_step, 2 inv_step_sq; write only
//   while idle, cfg_ready_o is always high.
// timing:
//   results pass the stencil register and the magnitude, product and round
//   stages. one sample and one result per cycle sustained while out_stall_i
//   is low; the output port gives one beat a cycle, so the input is held
//   after sample 3 and the last sample while more than one result is pending.
// reset: line_length 4, steps 1.0, position 0, pipeline empty.
// out_stall_i freezes the whole pipeline while out_valid_o is high; in_stall_o
// rises with it once a beat is pending issue.
module finite_difference_line_derivatives_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [fdld_pkg::DataW-1:0]   sample_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [fdld_pkg::DataW-1:0]   slope_o,
  output logic [fdld_pkg::DataW-1:0]   curvature_o,
  output logic [fdld_pkg::IdxW-1:0]    point_index_o,
  output logic                         end_of_line_o,
  output logic                         last_of_run_o,
  output logic                         saturated_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [fdld_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [fdld_pkg::DataW-1:0]   cfg_data_i
);

  localparam int unsigned PosW    = fdld_pkg::PosW;
  localparam int unsigned LenEffW = fdld_pkg::LenEffW;
  localparam int unsigned IdxW    = fdld_pkg::IdxW;
  localparam int unsigned SumW    = fdld_pkg::SumW;
  localparam int unsigned DataW   = fdld_pkg::DataW;
  localparam int unsigned Taps    = 4;
  localparam int unsigned Stages  = 4;
  localparam int unsigned JobFwd   = 0;
  localparam int unsigned JobCenLo = 1;
  localparam int unsigned JobCenHi = 2;
  localparam int unsigned JobBwd   = 3;

  typedef struct packed {
    logic [IdxW-1:0] idx;
    logic            eol;
    logic            last;
  } meta_t;

  logic [fdld_pkg::LenW-1:0] cfg_len_q;
  logic [DataW-1:0]          cfg_inv_q;
  logic [DataW-1:0]          cfg_inv_sq_q;

  logic [PosW-1:0]    pos_q;
  logic [PosW-1:0]    pos_d;
  logic [Taps-1:0]    pend_q;
  logic [Taps-1:0]    pend_d;
  logic [Taps-1:0]    pend_rest;
  logic [Taps-1:0]    jobs;
  logic [PosW-1:0]    jpos_q;
  logic               jend_q;
  logic [LenEffW-1:0] len_eff;
  logic               at_end;
  logic               adv;
  logic               in_acc;
  logic               issue;

  fdld_pkg::sample_t win [Taps];
  fdld_pkg::sum_t    ext [Taps];
  fdld_pkg::sum_t    ns_d;
  fdld_pkg::sum_t    nc_d;
  fdld_pkg::sum_t    ns_q;
  fdld_pkg::sum_t    nc_q;
  meta_t             meta_d;
  meta_t             meta_q [Stages];
  logic [Stages-1:0] v_q;
  logic              sat_s;
  logic              sat_c;
  fdld_pkg::sample_t slope_res;
  fdld_pkg::sample_t curv_res;

  // handshake and job bookkeeping
  assign adv        = !v_q[Stages-1] || !out_stall_i;
  assign issue      = adv && (pend_q != '0);
  assign pend_rest  = pend_q & (pend_q - Taps'(1));
  assign in_stall_o = (pend_q != '0) && (!adv || (pend_rest != '0));
  assign in_acc     = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    if (32'(cfg_len_q) > fdld_pkg::MaxLine) begin
      len_eff = LenEffW'(fdld_pkg::MaxLine);
    end else if (32'(cfg_len_q) < fdld_pkg::MinLine) begin
      len_eff = LenEffW'(fdld_pkg::MinLine);
    end else begin
      len_eff = LenEffW'(cfg_len_q);
    end
    at_end = {1'b0, pos_q} >= (len_eff - LenEffW'(1));
  end

  always_comb begin
    jobs  = '0;
    pos_d = pos_q + PosW'(1);
    if (pos_q == PosW'(3)) begin
      jobs[JobFwd]   = 1'b1;
      jobs[JobCenLo] = 1'b1;
      jobs[JobCenHi] = 1'b1;
      jobs[JobBwd]   = at_end;
    end else if (pos_q > PosW'(3)) begin
      jobs[JobCenHi] = 1'b1;
      jobs[JobBwd]   = at_end;
    end
    if (pos_q >= PosW'(3) && at_end) begin
      pos_d = '0;
    end
  end

  always_comb begin
    pend_d = pend_q;
    if (issue) begin
      pend_d = pend_rest;
    end
    if (in_acc) begin
      pend_d = jobs;
    end
  end

  // sample window
  for (genvar g = 0; g < Taps; g++) begin : g_cell
    fdld_pkg::sample_t cell_d;
    if (g == Taps - 1) begin : g_head
      assign cell_d = fdld_pkg::sample_t'(sample_i);
    end else begin : g_link
      assign cell_d = win[g+1];
    end
    fdld_cell u_cell (
      .clk_i (clk_i),
      .en_i  (in_acc),
      .d_i   (cell_d),
      .q_o   (win[g])
    );
    assign ext[g] = SumW'(win[g]);
  end

  // stencil selection, one job per cycle while the pipeline advances
  always_comb begin
    ns_d        = '0;
    nc_d        = '0;
    meta_d.idx  = '0;
    meta_d.eol  = 1'b0;
    meta_d.last = 1'b0;
    if (pend_q[JobFwd]) begin
      ns_d = (ext[1] <<< 2) - (ext[0] * 3) - ext[2];
      nc_d = (ext[0] <<< 1) - (ext[1] * 5) + (ext[2] <<< 2) - ext[3];
    end else if (pend_q[JobCenLo]) begin
      ns_d       = ext[2] - ext[0];
      nc_d       = ext[2] - (ext[1] <<< 1) + ext[0];
      meta_d.idx = IdxW'(1);
    end else if (pend_q[JobCenHi]) begin
      ns_d        = ext[3] - ext[1];
      nc_d        = ext[3] - (ext[2] <<< 1) + ext[1];
      meta_d.idx  = IdxW'(jpos_q - PosW'(1));
      meta_d.last = !jend_q;
    end else begin
      ns_d        = (ext[3] * 3) - (ext[2] <<< 2) + ext[1];
      nc_d        = (ext[3] <<< 1) - (ext[2] * 5) + (ext[1] <<< 2) - ext[0];
      meta_d.idx  = IdxW'(jpos_q);
      meta_d.eol  = 1'b1;
      meta_d.last = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_len_q    <= fdld_pkg::LenW'(fdld_pkg::MinLine);
      cfg_inv_q    <= DataW'(32'h0001_0000);
      cfg_inv_sq_q <= DataW'(32'h0001_0000);
      pos_q        <= '0;
      pend_q       <= '0;
      v_q          <= '0;
    end else begin
      if (cfg_valid_i) begin
        case (fdld_pkg::cfg_reg_e'(cfg_index_i))
          fdld_pkg::CfgLineLength: cfg_len_q    <= cfg_data_i[fdld_pkg::LenW-1:0];
          fdld_pkg::CfgInvStep:    cfg_inv_q    <= cfg_data_i;
          fdld_pkg::CfgInvStepSq:  cfg_inv_sq_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (in_acc) begin
        pos_q <= pos_d;
      end
      pend_q <= pend_d;
      if (adv) begin
        v_q <= {v_q[Stages-2:0], issue};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      jpos_q <= pos_q;
      jend_q <= at_end;
    end
    if (adv) begin
      ns_q      <= ns_d;
      nc_q      <= nc_d;
      meta_q[0] <= meta_d;
      for (int i = 1; i < Stages; i++) begin
        meta_q[i] <= meta_q[i-1];
      end
    end
  end

  fdld_scale u_slope (
    .clk_i  (clk_i),
    .en_i   (adv),
    .half_i (1'b1),
    .num_i  (ns_q),
    .k_i    (cfg_inv_q),
    .res_o  (slope_res),
    .sat_o  (sat_s)
  );

  fdld_scale u_curv (
    .clk_i  (clk_i),
    .en_i   (adv),
    .half_i (1'b0),
    .num_i  (nc_q),
    .k_i    (cfg_inv_sq_q),
    .res_o  (curv_res),
    .sat_o  (sat_c)
  );

  assign out_valid_o   = v_q[Stages-1];
  assign slope_o       = DataW'(slope_res);
  assign curvature_o   = DataW'(curv_res);
  assign point_index_o = meta_q[Stages-1].idx;
  assign end_of_line_o = meta_q[Stages-1].eol;
  assign last_of_run_o = meta_q[Stages-1].last;
  assign saturated_o   = sat_s | sat_c;

`ifndef ASSERT_OFF
  a_eol_is_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && end_of_line_o) |-> last_of_run_o)
    else $error("end of line beat without last_of_run");

  a_accept_drains : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> ((pend_q == '0) || ($onehot(pend_q) && adv)))
    else $error("input taken while jobs still pending");

  a_first_point_jobs : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && pos_q == PosW'(3)) |=> ($countones(pend_q) >= 3))
    else $error("fourth sample did not queue the first points");

  a_fill_no_jobs : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && pos_q < PosW'(3)) |=> (pend_q == '0))
    else $error("window fill sample queued a result");
`endif

endmodule

>>> tb/sv/tb_finite_difference_line_derivatives_unit.sv
// ----------------------------------------------------------------------------
// tb_finite_difference_line_derivatives_unit
// Streams grid lines through the derivative unit and checks every point's
// slope, curvature, index and flags against a predictor kept in step with the
// accepted samples, with random flow control on both sides and output hold-offs.
// ----------------------------------------------------------------------------
module tb_finite_difference_line_derivatives_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DataW        = fdld_pkg::DataW;
  localparam int unsigned IdxW         = fdld_pkg::IdxW;
  localparam int unsigned LenW         = fdld_pkg::LenW;
  localparam int unsigned SumW         = fdld_pkg::SumW;
  localparam int unsigned ProdW        = fdld_pkg::ProdW;
  localparam int unsigned CfgIdxW      = fdld_pkg::CfgIdxW;
  localparam int unsigned ClkPeriod    = 20;
  localparam int unsigned SettleCycles = 10;
  localparam int unsigned HoldCycles   = 80;
  localparam int unsigned CycleLimit   = 500000;
  localparam logic [CfgIdxW-1:0] CfgUnused = 2'd3;

  typedef struct packed {
    logic [DataW-1:0] slope;
    logic [DataW-1:0] curvature;
    logic [IdxW-1:0]  point_index;
    logic             end_of_line;
    logic             last_of_run;
    logic             saturated;
  } deriv_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [DataW-1:0]   sample_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [DataW-1:0]   slope_o;
  logic [DataW-1:0]   curvature_o;
  logic [IdxW-1:0]    point_index_o;
  logic               end_of_line_o;
  logic               last_of_run_o;
  logic               saturated_o;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [DataW-1:0]   cfg_data_i;

  // predictor state
  fdld_pkg::sample_t recent [4] = '{default: '0};
  int unsigned       next_point = 0;
  logic [LenW-1:0]   len_setting = LenW'(fdld_pkg::MinLine);
  logic [DataW-1:0]  rstep = 32'h0001_0000;
  logic [DataW-1:0]  rstep_sq = 32'h0001_0000;

  deriv_t pending_derivs [$];
  int     fail_count = 0;
  int     tx_idle_pct = 0;
  int     rx_idle_pct = 0;
  int     hold_requests = 0;
  bit     drain_mode = 1'b0;

  finite_difference_line_derivatives_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .sample_i      (sample_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .slope_o       (slope_o),
    .curvature_o   (curvature_o),
    .point_index_o (point_index_o),
    .end_of_line_o (end_of_line_o),
    .last_of_run_o (last_of_run_o),
    .saturated_o   (saturated_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  // round half away from zero on the magnitude, then clip; msb is the clip flag
  function automatic logic [DataW:0] scale_round(fdld_pkg::sum_t num, logic [DataW-1:0] k,
                                                 int unsigned shift);
    logic [SumW-1:0]  mag;
    logic [ProdW-1:0] prod;
    logic [ProdW-1:0] q;
    mag  = num[SumW-1] ? SumW'(-num) : SumW'(num);
    prod = ProdW'(mag) * ProdW'(k);
    q    = (prod + (ProdW'(1) << (shift - 1))) >> shift;
    if (num[SumW-1]) begin
      if (q > ProdW'(32'h8000_0000)) return {1'b1, 32'h8000_0000};
      return {1'b0, DataW'(-q[DataW-1:0])};
    end
    if (q > ProdW'(32'h7FFF_FFFF)) return {1'b1, 32'h7FFF_FFFF};
    return {1'b0, q[DataW-1:0]};
  endfunction

  function automatic deriv_t make_deriv(fdld_pkg::sum_t n_slope, fdld_pkg::sum_t n_curv,
                                        int unsigned idx, logic eol, logic last);
    logic [DataW:0] s;
    logic [DataW:0] c;
    deriv_t d;
    s = scale_round(n_slope, rstep, fdld_pkg::SlopeShift);
    c = scale_round(n_curv, rstep_sq, fdld_pkg::CurvShift);
    d.slope       = s[DataW-1:0];
    d.curvature   = c[DataW-1:0];
    d.point_index = IdxW'(idx);
    d.end_of_line = eol;
    d.last_of_run = last;
    d.saturated   = s[DataW] | c[DataW];
    return d;
  endfunction

  task automatic predict_sample(input logic [DataW-1:0] smp);
    int unsigned lim;
    int unsigned p;
    logic at_end;
    fdld_pkg::sum_t w0;
    fdld_pkg::sum_t w1;
    fdld_pkg::sum_t w2;
    fdld_pkg::sum_t w3;
    lim = len_setting;
    if (lim < fdld_pkg::MinLine) lim = fdld_pkg::MinLine;
    if (lim > fdld_pkg::MaxLine) lim = fdld_pkg::MaxLine;
    recent[0] = recent[1];
    recent[1] = recent[2];
    recent[2] = recent[3];
    recent[3] = smp;
    w0 = recent[0];
    w1 = recent[1];
    w2 = recent[2];
    w3 = recent[3];
    p = next_point;
    at_end = (p >= lim - 1);
    if (p < 3) begin
      next_point = p + 1;
      return;
    end
    if (p == 3) begin
      pending_derivs.push_back(make_deriv(-3 * w0 + 4 * w1 - w2,
                                          2 * w0 - 5 * w1 + 4 * w2 - w3, 0, 1'b0, 1'b0));
      pending_derivs.push_back(make_deriv(w2 - w0, w2 - 2 * w1 + w0, 1, 1'b0, 1'b0));
      pending_derivs.push_back(make_deriv(w3 - w1, w3 - 2 * w2 + w1, 2, 1'b0, !at_end));
    end else begin
      pending_derivs.push_back(make_deriv(w3 - w1, w3 - 2 * w2 + w1, p - 1, 1'b0, !at_end));
    end
    if (at_end) begin
      pending_derivs.push_back(make_deriv(3 * w3 - 4 * w2 + w1,
                                          2 * w3 - 5 * w2 + 4 * w1 - w0, p, 1'b1, 1'b1));
      next_point = 0;
    end else begin
      next_point = p + 1;
    end
  endtask

  task automatic send_sample(input logic [DataW-1:0] smp);
    while ($urandom_range(99) < tx_idle_pct) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    sample_i   <= smp;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    predict_sample(smp);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [DataW-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    case (idx)
      fdld_pkg::CfgLineLength: len_setting = val[LenW-1:0];
      fdld_pkg::CfgInvStep:    rstep = val;
      fdld_pkg::CfgInvStepSq:  rstep_sq = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // sender pauses until every result is out and the pipeline has emptied
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    drain_mode = 1'b1;
    while (pending_derivs.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    drain_mode = 1'b0;
  endtask

  function automatic logic [DataW-1:0] rand_sample();
    logic [DataW-1:0] r;
    r = $urandom;
    case ($urandom_range(5))
      0: return r;
      1: return r[0] ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return {{12{r[19]}}, r[19:0]};
    endcase
  endfunction

  function automatic logic [DataW-1:0] rand_step();
    logic [DataW-1:0] r;
    r = $urandom;
    case ($urandom_range(5))
      0: return '0;
      1: return 32'hFFFF_FFFF;
      2: return 32'h0001_0000;
      3: return {14'b0, r[17:0]};
      default: return r;
    endcase
  endfunction

  function automatic logic [DataW-1:0] rand_length();
    case ($urandom_range(9))
      0: return $urandom_range(0, 3);
      1: return $urandom_range(13, 48);
      default: return $urandom_range(4, 12);
    endcase
  endfunction

  task automatic test_reset_defaults();
    send_sample(32'h7FFF_FFFF);
    send_sample(32'h8000_0000);
    send_sample(32'h7FFF_FFFF);
    send_sample(32'h8000_0000);
  endtask

  task automatic test_short_length_rounding();
    wait_idle();
    write_reg(fdld_pkg::CfgLineLength, 32'd0);
    write_reg(fdld_pkg::CfgInvStep, 32'h0000_0001);
    write_reg(fdld_pkg::CfgInvStepSq, 32'h0000_8000);
    send_sample(32'h0000_0000);
    send_sample(32'h0000_0001);
    send_sample(32'h0001_0000);
    send_sample(32'hFFFF_FFFD);
  endtask

  task automatic test_interior_points();
    wait_idle();
    write_reg(fdld_pkg::CfgLineLength, 32'd6);
    write_reg(fdld_pkg::CfgInvStep, 32'hFFFF_FFFF);
    write_reg(fdld_pkg::CfgInvStepSq, 32'h0000_0000);
    send_sample(32'h0000_0000);
    send_sample(32'h0000_0000);
    send_sample(32'h0000_0010);
    send_sample(32'h0000_0010);
    send_sample(32'hFFFF_FFFB);
    send_sample(32'h7FFF_FFFF);
  endtask

  task automatic test_length_cut_mid_line();
    int i;
    wait_idle();
    write_reg(fdld_pkg::CfgLineLength, 32'h0000_1000);
    write_reg(fdld_pkg::CfgInvStep, 32'h0001_0000);
    write_reg(fdld_pkg::CfgInvStepSq, 32'hFFFF_FFFF);
    for (i = 0; i < 6; i++) send_sample(rand_sample());
    wait_idle();
    // new length already passed: next sample closes the line
    write_reg(fdld_pkg::CfgLineLength, 32'd5);
    send_sample(rand_sample());
    wait_idle();
    write_reg(CfgUnused, 32'd4);
    for (i = 0; i < 5; i++) send_sample(rand_sample());
  endtask

  task automatic test_longest_line();
    int i;
    wait_idle();
    write_reg(fdld_pkg::CfgLineLength, 32'h0000_1FFF);
    write_reg(fdld_pkg::CfgInvStep, 32'h0004_0000);
    write_reg(fdld_pkg::CfgInvStepSq, 32'h0010_0000);
    for (i = 0; i < 9; i++) send_sample(rand_sample());
    wait_idle();
    // shortest length closes the clamped line on the next beat
    write_reg(fdld_pkg::CfgLineLength, 32'd4);
    send_sample(rand_sample());
  endtask

  task automatic test_input_backpressure();
    int i;
    tx_idle_pct = 0;
    wait_idle();
    write_reg(fdld_pkg::CfgLineLength, 32'd24);
    hold_requests++;
    for (i = 0; i < 24; i++) send_sample(rand_sample());
    wait_idle();
  endtask

  task automatic test_random_lines(input int tx_pct, input int rx_pct, input int n_items);
    int sent;
    int cut_at;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(2) == 0) begin
        wait_idle();
        write_reg(fdld_pkg::CfgLineLength, rand_length());
        if ($urandom_range(1) == 0) write_reg(fdld_pkg::CfgInvStep, rand_step());
        if ($urandom_range(1) == 0) write_reg(fdld_pkg::CfgInvStepSq, rand_step());
        if ($urandom_range(7) == 0) write_reg(CfgUnused, $urandom);
      end
      cut_at = ($urandom_range(6) == 0) ? $urandom_range(1, 8) : -1;
      do begin
        send_sample(rand_sample());
        sent++;
        if (next_point == cut_at) begin
          wait_idle();
          write_reg(fdld_pkg::CfgLineLength, $urandom_range(0, cut_at));
        end
      end while (next_point != 0);
    end
  endtask

  initial begin : rx_pacing
    int seen;
    int hold_left;
    seen        = 0;
    hold_left   = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_requests != seen) begin
        seen      = hold_requests;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left = hold_left - 1;
      end else if (drain_mode) begin
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= ($urandom_range(99) < rx_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    deriv_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (pending_derivs.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected result beat: idx %0d slope %h curv %h",
                   point_index_o, slope_o, curvature_o);
      end else begin
        want = pending_derivs.pop_front();
        if (slope_o !== want.slope || curvature_o !== want.curvature ||
            point_index_o !== want.point_index || end_of_line_o !== want.end_of_line ||
            last_of_run_o !== want.last_of_run || saturated_o !== want.saturated) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("mismatch exp: slope %h curv %h idx %0d eol %b last %b sat %b",
                     want.slope, want.curvature, want.point_index, want.end_of_line,
                     want.last_of_run, want.saturated);
            $display("         got: slope %h curv %h idx %0d eol %b last %b sat %b",
                     slope_o, curvature_o, point_index_o, end_of_line_o,
                     last_of_run_o, saturated_o);
          end
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    sample_i    = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = fdld_pkg::CfgLineLength;
    cfg_data_i  = '0;
    tx_idle_pct = 34;
    rx_idle_pct = 45;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_defaults();
    test_short_length_rounding();
    test_interior_points();
    test_length_cut_mid_line();
    test_longest_line();
    test_input_backpressure();
    test_random_lines(34, 45, 40);
    test_random_lines(45, 34, 40);
    test_random_lines(0, 0, 40);

    wait_idle();
    repeat (SettleCycles) @(posedge clk_i);
    if (fail_count == 0 && pending_derivs.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
